### hdl/bcu_pkg.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit package
// Item types, microcode word layout and the control program of the sequencer.
// ----------------------------------------------------------------------------
package bcu_pkg;

  // Input item: n and k of C(n,k)
  typedef struct packed {
    logic [7:0] n_value;
    logic [7:0] k_value;
  } bcu_in_t;

  // Result item: coefficient and overflow flag
  typedef struct packed {
    logic [30:0] coefficient;
    logic        overflow;
  } bcu_out_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_NOP,
    OP_FMUL,
    OP_FALL_UPD,
    OP_ZERO,
    OP_SETI,
    OP_KMUL,
    OP_FACT_UPD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } bcu_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_FALL_DONE,
    C_I_GE_N,
    C_FACT_DONE,
    C_OVF,
    C_DIV_MORE
  } bcu_cond_t;

  localparam int PcWidth = 4;
  typedef logic [PcWidth-1:0] bcu_pc_t;

  // One control word: operation, jump condition, jump target
  typedef struct packed {
    bcu_op_t   op;
    bcu_cond_t cond;
    bcu_pc_t   target;
  } bcu_uword_t;

  // Program addresses
  localparam bcu_pc_t PcIdle      = 4'd0;
  localparam bcu_pc_t PcFallTest  = 4'd1;
  localparam bcu_pc_t PcFallZero  = 4'd5;
  localparam bcu_pc_t PcFactStart = 4'd6;
  localparam bcu_pc_t PcFactTest  = 4'd7;
  localparam bcu_pc_t PcDivInit   = 4'd10;
  localparam bcu_pc_t PcDivStep   = 4'd11;
  localparam bcu_pc_t PcOut       = 4'd12;

  // Control store contents
  function automatic bcu_uword_t bcu_ucode(input bcu_pc_t pc);
    bcu_uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,  target: PcIdle};
      4'd1:    w = '{op: OP_NOP,      cond: C_FALL_DONE, target: PcFactStart};
      4'd2:    w = '{op: OP_NOP,      cond: C_I_GE_N,    target: PcFallZero};
      4'd3:    w = '{op: OP_FMUL,     cond: C_NEVER,     target: PcIdle};
      4'd4:    w = '{op: OP_FALL_UPD, cond: C_ALWAYS,    target: PcFallTest};
      4'd5:    w = '{op: OP_ZERO,     cond: C_ALWAYS,    target: PcFactStart};
      4'd6:    w = '{op: OP_SETI,     cond: C_NEVER,     target: PcIdle};
      4'd7:    w = '{op: OP_NOP,      cond: C_FACT_DONE, target: PcDivInit};
      4'd8:    w = '{op: OP_KMUL,     cond: C_NEVER,     target: PcIdle};
      4'd9:    w = '{op: OP_FACT_UPD, cond: C_ALWAYS,    target: PcFactTest};
      4'd10:   w = '{op: OP_DIV_INIT, cond: C_OVF,       target: PcOut};
      4'd11:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: PcDivStep};
      4'd12:   w = '{op: OP_OUT,      cond: C_ALWAYS,    target: PcIdle};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PcIdle};
    endcase
    return w;
  endfunction

  // Control from sequencer to datapath
  typedef struct packed {
    bcu_op_t op;
  } bcu_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_pending;
    logic fall_done;
    logic i_ge_n;
    logic fact_done;
    logic ovf;
    logic div_more;
    logic out_busy;
  } bcu_status_t;

endpackage

### hdl/bcu_sequencer.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module bcu_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  bcu_pkg::bcu_status_t status,
  output bcu_pkg::bcu_ctrl_t   ctrl
);
  import bcu_pkg::*;

  bcu_pc_t    pc_r;
  bcu_pc_t    pc_nxt;
  bcu_uword_t uword;
  logic       taken;
  logic       hold;

  // Fetch the current control word
  assign uword   = bcu_ucode(pc_r);
  assign ctrl.op = uword.op;

  // Evaluate the jump condition
  always_comb begin
    case (uword.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_INPUT:  taken = !status.in_pending;
      C_FALL_DONE: taken = status.fall_done;
      C_I_GE_N:    taken = status.i_ge_n;
      C_FACT_DONE: taken = status.fact_done;
      C_OVF:       taken = status.ovf;
      C_DIV_MORE:  taken = status.div_more;
      default:     taken = 1'b1;
    endcase
  end

  // Hold on the output step while the result register is still full
  assign hold = (uword.op == OP_OUT) && status.out_busy;

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uword.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PcIdle;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### hdl/bcu_datapath.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit datapath
// Shared checked multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module bcu_datapath #(
  parameter int RESULT_WIDTH = 32,
  parameter int ARG_WIDTH    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcu_pkg::bcu_ctrl_t   ctrl,
  input  logic                 in_valid,
  input  bcu_pkg::bcu_in_t     in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output bcu_pkg::bcu_out_t    out_data,
  output bcu_pkg::bcu_status_t status
);
  import bcu_pkg::*;

  localparam int PW  = RESULT_WIDTH - 1;  // product magnitude bits
  localparam int PDW = PW + ARG_WIDTH;    // full multiplier width
  localparam int CW  = $clog2(PW);        // divide step counter

  logic [ARG_WIDTH-1:0] n_r;
  logic [ARG_WIDTH-1:0] k_r;
  logic [ARG_WIDTH-1:0] i_r;
  logic [PW-1:0]        fall_r;
  logic [PW-1:0]        fact_r;
  logic [PW-1:0]        rem_r;
  logic [PDW-1:0]       prod_r;
  logic [CW-1:0]        cnt_r;
  logic                 ovf_r;
  logic                 out_valid_r;
  bcu_out_t             out_data_r;

  logic [PW-1:0]        mul_a;
  logic [ARG_WIDTH-1:0] mul_b;
  logic [PDW-1:0]       prod_nxt;
  logic                 prod_ovf;
  logic [PW:0]          rem_sh;
  logic [PW:0]          diff;
  logic                 q_bit;
  logic [PW-1:0]        rem_nxt;

  // Share one multiplier between the falling product and the factorial
  always_comb begin
    if (ctrl.op == OP_KMUL) begin
      mul_a = fact_r;
      mul_b = i_r;
    end else begin
      mul_a = fall_r;
      mul_b = n_r - i_r;
    end
    prod_nxt = PDW'(mul_a) * PDW'(mul_b);
  end

  // Any bit above the signed bound means overflow
  assign prod_ovf = |prod_r[PDW-1:PW];

  // One restoring divide step: quotient bits shift in through fall_r
  always_comb begin
    rem_sh  = {rem_r, fall_r[PW-1]};
    diff    = rem_sh - {1'b0, fact_r};
    q_bit   = !diff[PW];
    rem_nxt = q_bit ? diff[PW-1:0] : rem_sh[PW-1:0];
  end

  // Execute the current micro-operation
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          n_r    <= ARG_WIDTH'(in_data.n_value);
          k_r    <= ARG_WIDTH'(in_data.k_value);
          i_r    <= '0;
          fall_r <= PW'(1);
          fact_r <= PW'(1);
          ovf_r  <= 1'b0;
        end
      end
      OP_FMUL, OP_KMUL: begin
        prod_r <= prod_nxt;
      end
      OP_FALL_UPD: begin
        if (prod_ovf) begin
          ovf_r <= 1'b1;
        end else begin
          fall_r <= prod_r[PW-1:0];
          i_r    <= i_r + 1'b1;
        end
      end
      OP_ZERO: begin
        fall_r <= '0;
      end
      OP_SETI: begin
        i_r <= k_r;
      end
      OP_FACT_UPD: begin
        if (prod_ovf) begin
          ovf_r <= 1'b1;
        end else begin
          fact_r <= prod_r[PW-1:0];
          i_r    <= i_r - 1'b1;
        end
      end
      OP_DIV_INIT: begin
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r  <= rem_nxt;
        fall_r <= {fall_r[PW-2:0], q_bit};
        cnt_r  <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: load on the output step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_OUT && !(out_valid_r && out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT && !(out_valid_r && out_stall)) begin
      out_data_r.coefficient <= ovf_r ? 31'd0 : 31'(fall_r);
      out_data_r.overflow    <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Report status to the sequencer
  always_comb begin
    status.in_pending = in_valid;
    status.fall_done  = (i_r == k_r) || ovf_r;
    status.i_ge_n     = (i_r >= n_r);
    status.fact_done  = (i_r == '0) || ovf_r;
    status.ovf        = ovf_r;
    status.div_more   = (cnt_r != CW'(PW - 1));
    status.out_busy   = out_valid_r && out_stall;
  end

endmodule

### hdl/binomial_coefficient_unit.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit
// Computes C(n,k) as the falling product of n over k! with overflow detect.
// ----------------------------------------------------------------------------
// Usage:
//   An item (n_value, k_value) enters on in_data when in_valid is high and
//   in_stall is low. One item comes back on out_data per input item, with
//   coefficient = C(n,k) and overflow = 0, or coefficient = 0 and
//   overflow = 1 when a partial product of n(n-1)...(n-k+1) or of k!
//   passes 2^(RESULT_WIDTH-1)-1. n and k are taken modulo 2^ARG_WIDTH.
//   One item is worked on at a time; in_stall is low only while the
//   sequencer waits at its idle step.
//   The four-step falling product loop and three-step factorial loop run
//   around the one shared multiplier, then the divider takes one restoring
//   divide step per quotient bit. A waiting item is accepted in the cycle
//   after the result is loaded.
//   A finished result sits in an output register; the next item is
//   accepted while it waits. If out_stall holds that register full, the
//   sequencer waits at its output step. Reset empties the output register
//   and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit #(
  parameter int RESULT_WIDTH = 32,
  parameter int ARG_WIDTH    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bcu_pkg::bcu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bcu_pkg::bcu_out_t out_data
);
  import bcu_pkg::*;

  bcu_ctrl_t   ctrl;
  bcu_status_t status;

  // Take an item only at the idle step
  assign in_stall = (ctrl.op != OP_ACCEPT);

  bcu_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  bcu_datapath #(
    .RESULT_WIDTH (RESULT_WIDTH),
    .ARG_WIDTH    (ARG_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

### tb/sv/tb_binomial_coefficient_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Sends (n, k) items with random gaps and checks every returned coefficient
// and overflow flag against a falling-product / factorial predictor. Random
// stalls on the result side, with one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_unit;
  import bcu_pkg::*;

  localparam int          ResultWidth = 32;
  localparam int          RandomItems = 1100;
  localparam int          DirectedCnt = 22;
  localparam int unsigned CycleLimit  = 10_000_000;
  localparam int          DrainCycles = 2000;

  // Holds predicted results in order and checks returned items against them
  class coefficient_board;
    bcu_out_t expected_coefficients[$];
    int       mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Falling product over k!, zero with the flag set on any product overflow
    function bcu_out_t predict_coefficient(bcu_in_t item);
      longint unsigned prod_max;
      longint unsigned n;
      longint unsigned k;
      longint unsigned fall;
      longint unsigned fact;
      longint unsigned i;
      bit              ovf;
      bcu_out_t        res;
      prod_max = (64'd1 << (ResultWidth - 1)) - 1;
      n        = item.n_value;
      k        = item.k_value;
      fall     = 1;
      fact     = 1;
      ovf      = 1'b0;
      // falling product stops at a zero factor
      for (i = 0; i < k; i++) begin
        if (i >= n) begin
          fall = 0;
          break;
        end
        if (fall > prod_max / (n - i)) begin
          ovf = 1'b1;
          break;
        end
        fall = fall * (n - i);
      end
      for (i = k; i > 0; i--) begin
        if (fact > prod_max / i) begin
          ovf = 1'b1;
          break;
        end
        fact = fact * i;
      end
      if (ovf) begin
        res.coefficient = '0;
        res.overflow    = 1'b1;
      end else begin
        res.coefficient = 31'(fall / fact);
        res.overflow    = 1'b0;
      end
      return res;
    endfunction

    function void note_item(bcu_in_t item);
      expected_coefficients.push_back(predict_coefficient(item));
    endfunction

    function void check_result(bcu_out_t got);
      bcu_out_t want;
      if (expected_coefficients.size() == 0) begin
        $display("%0t: unexpected result coefficient=%0d overflow=%0b",
                 $time, got.coefficient, got.overflow);
        mismatch_count++;
        return;
      end
      want = expected_coefficients.pop_front();
      if (got.coefficient !== want.coefficient) begin
        $display("%0t: coefficient mismatch expected=%0d actual=%0d",
                 $time, want.coefficient, got.coefficient);
        mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch expected=%0b actual=%0b",
                 $time, want.overflow, got.overflow);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_coefficients.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bcu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bcu_out_t out_data;

  coefficient_board board = new();
  bit               full_rate = 1'b0;
  int unsigned      cycle_count = 0;

  // Directed (n, k): extremes, k zero, k above n, overflow on either chain
  logic [7:0] dir_n [DirectedCnt] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd5,
                                      8'd10, 8'd255, 8'd255, 8'd255, 8'd255,
                                      8'd12, 8'd13, 8'd12, 8'd3, 8'd170, 8'd85,
                                      8'd1, 8'd127, 8'd128, 8'd34, 8'd35};
  logic [7:0] dir_k [DirectedCnt] = '{8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd2,
                                      8'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd12,
                                      8'd13, 8'd13, 8'd7, 8'd85, 8'd170, 8'd1,
                                      8'd128, 8'd127, 8'd6, 8'd6};

  binomial_coefficient_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both channels and hand accepted items to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_item(in_data);
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
      end
    end
  end

  // Stall the result side at random, except during the full-rate stretch
  always @(negedge clk) begin
    out_stall <= !full_rate && ($urandom_range(0, 99) < 34);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one item, with an optional gap first, and hold it until taken
  task automatic send_item(input logic [7:0] n, input logic [7:0] k);
    if (!full_rate && ($urandom_range(0, 99) < 34)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{n_value: n, k_value: k};
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  initial begin
    int         sel;
    logic [7:0] n;
    logic [7:0] k;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int d = 0; d < DirectedCnt; d++) begin
      send_item(dir_n[d], dir_k[d]);
    end

    // Mostly small sets that give real coefficients; some wide and k > n
    for (int r = 0; r < RandomItems; r++) begin
      full_rate = (r >= 400) && (r < 560);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        n = 8'($urandom_range(0, 40));
        k = 8'($urandom_range(0, (n + 2 < 14) ? n + 2 : 14));
      end else if (sel < 65) begin
        n = 8'($urandom_range(0, 255));
        k = 8'($urandom_range(0, 4));
      end else if (sel < 80) begin
        n = 8'($urandom_range(0, 20));
        k = n + 8'($urandom_range(1, 6));
      end else begin
        n = 8'($urandom_range(0, 255));
        k = 8'($urandom_range(0, 255));
      end
      send_item(n, k);
    end
    full_rate = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give a stray extra result time to show up
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
